[sv/pinhole_camera_ray_generation_assert.svh]
// Assertion helpers shared by the ray generator RTL.
`ifndef PINHOLE_CAMERA_RAY_GENERATION_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_GENERATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pcrg assertion failed");

// Next-cycle implication, disabled during reset.
`define PCRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pcrg assertion failed");

`endif

[sv/pcrg_pkg.sv]
package pcrg_pkg;

	// Configuration register file
	localparam int REG_W       = 48;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_ORIGIN   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_CENTER   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_U_VECTOR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_V_VECTOR = 3'd3;

	// The largest normalized magnitude lies in [2^SCALE_MSB, 2^(SCALE_MSB+1))
	localparam int SCALE_MSB = 20;
	localparam int SCALED_W  = 21;
	localparam int SQ_W      = 42;
	localparam int LEN2_W    = 44;
	localparam int ROOT_W    = 22;
	localparam int NUM_W     = 37;
	localparam int DEN_W     = 23;
	localparam int QUOT_W    = 15;

	typedef struct packed {
		logic [15:0] screen_s;
		logic [15:0] screen_t;
	} request_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [15:0] plane_x;
		logic signed [15:0] plane_y;
		logic signed [15:0] plane_z;
		logic               degenerate;
	} result_t;

	// Fields that travel beside the square root
	typedef struct packed {
		logic [2:0][SCALED_W-1:0] mag;
		logic [2:0]               neg;
		logic                     degenerate;
		logic [2:0][15:0]         plane;
	} side_t;

	// Fields that travel beside the dividers
	typedef struct packed {
		logic [2:0]       neg;
		logic             degenerate;
		logic [2:0][15:0] plane;
	} post_t;

endpackage

[sv/pinhole_camera_ray_generation.sv]
// Channel   Handshake              Payload
// request   start / busy           request   (screen_s, screen_t)
// result    result_valid strobe    result    (dir, plane point, degenerate)
// config    cfg_we                 cfg_index, cfg_wdata
//
// Fully pipelined: one request per cycle, busy is always low.
// The pipeline has 7 setup stages (products, plane point, magnitudes,
// leading one, scaling, squares, sum), 22 square root stages, 1 numerator
// stage, 15 divider stages and the output register.
// Reset clears the configuration registers and the valid pipeline.
// The receiver cannot stall; each result is shown for exactly one cycle.
module pinhole_camera_ray_generation #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  pcrg_pkg::request_t                   request,
	output logic                                 result_valid,
	output pcrg_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [pcrg_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pcrg_pkg::REG_W-1:0]           cfg_wdata
);

`include "pinhole_camera_ray_generation_assert.svh"

	localparam int CW   = COMPONENT_BITS;
	localparam int PRW  = CW + 18;
	localparam int AW   = CW + 20;
	localparam int PW   = CW + 4;
	localparam int DW   = CW + 5;
	localparam int MW   = DW;
	localparam int POSW = $clog2(MW);
	localparam int XW   = MW + pcrg_pkg::SCALED_W;
	localparam int SW   = pcrg_pkg::SCALED_W;
	localparam int LAT  = 9 + pcrg_pkg::ROOT_W + pcrg_pkg::QUOT_W;

	localparam logic signed [AW-1:0] RND  = AW'(32768);
	localparam logic signed [PW-1:0] PMAX = PW'(32767);
	localparam logic signed [PW-1:0] PMIN = PW'(-32768);

	// Configuration registers
	logic [pcrg_pkg::REG_W-1:0] origin_q, center_q, u_q, v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			center_q <= '0;
			u_q      <= '0;
			v_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcrg_pkg::REG_CAMERA_ORIGIN:   origin_q <= cfg_wdata;
				pcrg_pkg::REG_SCREEN_CENTER:   center_q <= cfg_wdata;
				pcrg_pkg::REG_SCREEN_U_VECTOR: u_q      <= cfg_wdata;
				pcrg_pkg::REG_SCREEN_V_VECTOR: v_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Unpack components; bits beyond the register read as zero
	logic [3*CW+pcrg_pkg::REG_W-1:0] org_w, ctr_w, u_w, v_w;
	logic signed [CW-1:0] org_c [3];
	logic signed [CW-1:0] ctr_c [3];
	logic signed [CW-1:0] u_c   [3];
	logic signed [CW-1:0] v_c   [3];

	assign org_w = {{(3*CW){1'b0}}, origin_q};
	assign ctr_w = {{(3*CW){1'b0}}, center_q};
	assign u_w   = {{(3*CW){1'b0}}, u_q};
	assign v_w   = {{(3*CW){1'b0}}, v_q};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			org_c[i] = $signed(org_w[i*CW +: CW]);
			ctr_c[i] = $signed(ctr_w[i*CW +: CW]);
			u_c[i]   = $signed(u_w[i*CW +: CW]);
			v_c[i]   = $signed(v_w[i*CW +: CW]);
		end
	end

	// Valid pipeline
	logic           accept;
	logic [LAT-1:0] valid_s;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[LAT-2:0], accept};
		end
	end

	// Stage 1: map s,t to [-1,1) and multiply by the screen vectors
	logic signed [17:0]     sp, tp;
	logic signed [PRW-1:0]  pu_s1 [3];
	logic signed [PRW-1:0]  pv_s1 [3];

	assign sp = $signed({1'b0, request.screen_s, 1'b0}) - 18'sd65536;
	assign tp = $signed({1'b0, request.screen_t, 1'b0}) - 18'sd65536;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pu_s1[i] <= sp * u_c[i];
			pv_s1[i] <= tp * v_c[i];
		end
	end

	// Stage 2: add the center, round to Q.8, saturate the plane point, subtract the origin from the unsaturated point
	logic signed [AW-1:0] acc [3];
	logic signed [PW-1:0] pnt [3];
	logic signed [DW-1:0] d_s2 [3];
	logic [2:0][15:0]     plane_s2;
	logic [2:0][15:0]     plane_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = AW'(pu_s1[i]) + AW'(pv_s1[i]) + (AW'(ctr_c[i]) <<< 16) + RND;
			pnt[i] = $signed(acc[i][AW-1:16]);
			if (pnt[i] > PMAX) begin
				plane_c[i] = 16'h7fff;
			end else if (pnt[i] < PMIN) begin
				plane_c[i] = 16'h8000;
			end else begin
				plane_c[i] = pnt[i][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s2[i] <= DW'(pnt[i]) - DW'(org_c[i]);
		end
		plane_s2 <= plane_c;
	end

	// Stage 3: magnitudes, signs and the largest magnitude
	logic [MW-1:0]    mag_c [3];
	logic [MW-1:0]    max_c;
	logic [MW-1:0]    mag_s3 [3];
	logic [MW-1:0]    m_s3;
	logic [2:0]       neg_s3;
	logic [2:0][15:0] plane_s3;

	always_comb begin
		max_c = '0;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = d_s2[i][DW-1] ? MW'(-d_s2[i]) : MW'(d_s2[i]);
			if (mag_c[i] > max_c) begin
				max_c = mag_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s3[i] <= mag_c[i];
			neg_s3[i] <= d_s2[i][DW-1];
		end
		m_s3     <= max_c;
		plane_s3 <= plane_s2;
	end

	// Stage 4: find the leading one of the largest magnitude
	logic [POSW-1:0]  pos_c;
	logic [POSW-1:0]  pos_s4;
	logic [MW-1:0]    mag_s4 [3];
	logic [2:0]       neg_s4;
	logic             degen_s4;
	logic [2:0][15:0] plane_s4;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (m_s3[b]) begin
				pos_c = POSW'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s4   <= pos_c;
		mag_s4   <= mag_s3;
		neg_s4   <= neg_s3;
		degen_s4 <= (m_s3 == '0);
		plane_s4 <= plane_s3;
	end

	// Stage 5: scale all magnitudes so the largest sits at the target bit
	logic [XW-1:0]   wide [3];
	pcrg_pkg::side_t side_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pos_s4 >= POSW'(pcrg_pkg::SCALE_MSB)) begin
				wide[i] = XW'(mag_s4[i]) >> (pos_s4 - POSW'(pcrg_pkg::SCALE_MSB));
			end else begin
				wide[i] = XW'(mag_s4[i]) << (POSW'(pcrg_pkg::SCALE_MSB) - pos_s4);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			side_s5.mag[i] <= wide[i][SW-1:0];
		end
		side_s5.neg        <= neg_s4;
		side_s5.degenerate <= degen_s4;
		side_s5.plane      <= plane_s4;
	end

	// Stage 6: square the scaled magnitudes
	logic [pcrg_pkg::SQ_W-1:0] sq_s6 [3];
	pcrg_pkg::side_t           side_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= pcrg_pkg::SQ_W'(side_s5.mag[i]) * pcrg_pkg::SQ_W'(side_s5.mag[i]);
		end
		side_s6 <= side_s5;
	end

	// Stage 7: sum of squares
	logic [pcrg_pkg::LEN2_W-1:0] len2_s7;
	pcrg_pkg::side_t             side_s7;

	always_ff @(posedge clk) begin
		len2_s7 <= pcrg_pkg::LEN2_W'(sq_s6[0]) + pcrg_pkg::LEN2_W'(sq_s6[1])
			+ pcrg_pkg::LEN2_W'(sq_s6[2]);
		side_s7 <= side_s6;
	end

	// Square root, side fields delayed alongside
	logic [pcrg_pkg::ROOT_W-1:0] root;
	pcrg_pkg::side_t             side_dly_s [pcrg_pkg::ROOT_W];

	pcrg_sqrt u_sqrt (
		.clk      (clk),
		.radicand (len2_s7),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		side_dly_s[0] <= side_s7;
		for (int k = 1; k < pcrg_pkg::ROOT_W; k++) begin
			side_dly_s[k] <= side_dly_s[k-1];
		end
	end

	// Stage 8: form numerators with the rounding term and the doubled length
	logic [pcrg_pkg::NUM_W-1:0] num_s8 [3];
	logic [pcrg_pkg::DEN_W-1:0] den_s8;
	pcrg_pkg::post_t            post_s8;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s8[i] <= (pcrg_pkg::NUM_W'(side_dly_s[pcrg_pkg::ROOT_W-1].mag[i]) << 15)
				+ pcrg_pkg::NUM_W'(root);
		end
		den_s8             <= {root, 1'b0};
		post_s8.neg        <= side_dly_s[pcrg_pkg::ROOT_W-1].neg;
		post_s8.degenerate <= side_dly_s[pcrg_pkg::ROOT_W-1].degenerate;
		post_s8.plane      <= side_dly_s[pcrg_pkg::ROOT_W-1].plane;
	end

	// Dividers, one per component
	logic [pcrg_pkg::QUOT_W-1:0] quot [3];
	pcrg_pkg::post_t             post_dly_s [pcrg_pkg::QUOT_W];

	for (genvar i = 0; i < 3; i++) begin : g_div
		pcrg_div u_div (
			.clk  (clk),
			.num  (num_s8[i]),
			.den  (den_s8),
			.quot (quot[i])
		);
	end

	always_ff @(posedge clk) begin
		post_dly_s[0] <= post_s8;
		for (int k = 1; k < pcrg_pkg::QUOT_W; k++) begin
			post_dly_s[k] <= post_dly_s[k-1];
		end
	end

	// Output register: apply signs, zero a degenerate direction
	pcrg_pkg::post_t    post_o;
	logic signed [15:0] dir_c [3];
	pcrg_pkg::result_t  result_q;

	assign post_o = post_dly_s[pcrg_pkg::QUOT_W-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (post_o.degenerate) begin
				dir_c[i] = '0;
			end else if (post_o.neg[i]) begin
				dir_c[i] = -$signed(16'(quot[i]));
			end else begin
				dir_c[i] = $signed(16'(quot[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q.dir_x      <= dir_c[0];
		result_q.dir_y      <= dir_c[1];
		result_q.dir_z      <= dir_c[2];
		result_q.plane_x    <= $signed(post_o.plane[0]);
		result_q.plane_y    <= $signed(post_o.plane[1]);
		result_q.plane_z    <= $signed(post_o.plane[2]);
		result_q.degenerate <= post_o.degenerate;
	end

	assign result       = result_q;
	assign result_valid = valid_s[LAT-1];

	// Checks
	`PCRG_ASSERT_NEXT(a_accept_enters, clk, arst_n, accept, valid_s[0])
	`PCRG_ASSERT_IMP(a_scale_hits_msb, clk, arst_n, valid_s[4] && !side_s5.degenerate,
		side_s5.mag[0][SW-1] || side_s5.mag[1][SW-1] || side_s5.mag[2][SW-1])
	`PCRG_ASSERT_IMP(a_degen_zero_dir, clk, arst_n, result_valid && result.degenerate,
		result.dir_x == 16'sd0 && result.dir_y == 16'sd0 && result.dir_z == 16'sd0)
	`PCRG_ASSERT_IMP(a_dir_bounded, clk, arst_n, result_valid && !result.degenerate,
		result.dir_x <= 16'sd16384 && result.dir_x >= -16'sd16384
		&& result.dir_y <= 16'sd16384 && result.dir_y >= -16'sd16384
		&& result.dir_z <= 16'sd16384 && result.dir_z >= -16'sd16384)

endmodule

[sv/pcrg_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module pcrg_sqrt (
	input  logic                        clk,
	input  logic [pcrg_pkg::LEN2_W-1:0] radicand,
	output logic [pcrg_pkg::ROOT_W-1:0] root
);

	localparam int N = pcrg_pkg::ROOT_W;
	localparam int W = pcrg_pkg::LEN2_W + 1;

	logic [W-1:0] rem_s [1:N-1];
	logic [W-1:0] res_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
		logic [W-1:0] rem_in, res_in, trial, rem_nx, res_nx;

		if (k == 0) begin : g_first
			assign rem_in = W'(radicand);
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign res_in = res_s[k];
		end

		// Try the next root bit against the remainder
		always_comb begin
			trial = res_in + BIT;
			if (rem_in >= trial) begin
				rem_nx = rem_in - trial;
				res_nx = (res_in >> 1) + BIT;
			end else begin
				rem_nx = rem_in;
				res_nx = res_in >> 1;
			end
		end

		always_ff @(posedge clk) begin
			res_s[k+1] <= res_nx;
		end

		if (k < N - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[k+1] <= rem_nx;
			end
		end
	end

	assign root = res_s[N][N-1:0];

endmodule

[sv/pcrg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module pcrg_div (
	input  logic                        clk,
	input  logic [pcrg_pkg::NUM_W-1:0]  num,
	input  logic [pcrg_pkg::DEN_W-1:0]  den,
	output logic [pcrg_pkg::QUOT_W-1:0] quot
);

	localparam int Q  = pcrg_pkg::QUOT_W;
	localparam int RW = pcrg_pkg::NUM_W + 1;

	logic [RW-1:0]                 rem_s [1:Q-1];
	logic [pcrg_pkg::DEN_W-1:0]    den_s [1:Q-1];
	logic [Q-1:0]                  q_s   [1:Q];

	for (genvar j = 0; j < Q; j++) begin : g_stage
		localparam int K = Q - 1 - j;
		logic [RW-1:0]              rem_in, sub, rem_nx;
		logic [pcrg_pkg::DEN_W-1:0] den_in;
		logic [Q-1:0]               q_in, q_nx;

		if (j == 0) begin : g_first
			assign rem_in = RW'(num);
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[j];
			assign den_in = den_s[j];
			assign q_in   = q_s[j];
		end

		// Subtract the shifted divisor when it fits
		always_comb begin
			sub = RW'(den_in) << K;
			if (rem_in >= sub) begin
				rem_nx = rem_in - sub;
				q_nx   = {q_in[Q-2:0], 1'b1};
			end else begin
				rem_nx = rem_in;
				q_nx   = {q_in[Q-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			q_s[j+1] <= q_nx;
		end

		if (j < Q - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j+1] <= rem_nx;
				den_s[j+1] <= den_in;
			end
		end
	end

	assign quot = q_s[Q];

endmodule
